FILE: rtl/soc_pkg.sv
// shared types, constants and helper functions of the orbit camera
// used by every module of the block, no dependencies
package soc_pkg;

	localparam int DATA_W      = 32;
	localparam int NUM_CFG     = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int ACT_W       = 3;
	localparam int OUT_TDATA_W = 296;
	localparam int ANG_W       = 35;  // angle in units of 2^-24 degree
	localparam int XY_W        = 34;  // cordic vector, q2.30 with headroom
	localparam int MUL_W       = 34;
	localparam int D_W         = 36;  // scaled offset
	localparam int SUM_W       = 38;
	localparam int ANG_FRAC    = 24;
	localparam int TABLE_LEN   = 30;
	localparam int STEP_W      = 5;

	localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [ANG_W-1:0] ANG_90      = 35'sd1509949440;
	localparam logic signed [ANG_W-1:0] ANG_180     = 35'sd3019898880;
	localparam logic signed [ANG_W-1:0] ANG_360     = 35'sd6039797760;

	typedef enum logic [ACT_W-1:0] {
		ACT_PLACE      = 3'd0,
		ACT_DOLLY      = 3'd1,
		ACT_ORBIT_AZ   = 3'd2,
		ACT_ORBIT_POL  = 3'd3,
		ACT_PIVOT_RAD  = 3'd4,
		ACT_PIVOT_AZ   = 3'd5,
		ACT_PIVOT_POL  = 3'd6,
		ACT_FORWARD    = 3'd7
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RADIUS   = 3'd0,
		CFG_AZIMUTH  = 3'd1,
		CFG_POLAR    = 3'd2,
		CFG_TARGET_X = 3'd3,
		CFG_TARGET_Y = 3'd4,
		CFG_TARGET_Z = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MUL_U0,
		MUL_U1,
		MUL_D0,
		MUL_D1,
		MUL_D2
	} mul_step_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_APPLY,
		S_TRIG_AZ,
		S_WAIT_AZ,
		S_TRIG_POL,
		S_WAIT_POL,
		S_MUL_U0,
		S_MUL_U1,
		S_MUL_D0,
		S_MUL_D1,
		S_MUL_D2,
		S_UPDATE,
		S_OUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_MOD,
		T_PREP,
		T_ROT
	} trig_phase_t;

	typedef struct packed {
		logic      capture;
		logic      apply;
		logic      trig_start;
		logic      trig_sel;   // 0 azimuth, 1 polar
		logic      mul_en;
		mul_step_t mul_step;
		logic      update;
		logic      out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic trig_done;
	} dp_status_t;

	// atan(2^-i) in units of 2^-24 degree
	function automatic logic signed [ANG_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
		logic signed [ANG_W-1:0] r;
		unique case (i)
			5'd0:  r = 35'sd754974720;
			5'd1:  r = 35'sd445687602;
			5'd2:  r = 35'sd235489089;
			5'd3:  r = 35'sd119537938;
			5'd4:  r = 35'sd60000935;
			5'd5:  r = 35'sd30029717;
			5'd6:  r = 35'sd15018523;
			5'd7:  r = 35'sd7509719;
			5'd8:  r = 35'sd3754917;
			5'd9:  r = 35'sd1877466;
			5'd10: r = 35'sd938734;
			5'd11: r = 35'sd469367;
			5'd12: r = 35'sd234684;
			5'd13: r = 35'sd117342;
			5'd14: r = 35'sd58671;
			5'd15: r = 35'sd29335;
			5'd16: r = 35'sd14668;
			5'd17: r = 35'sd7334;
			5'd18: r = 35'sd3667;
			5'd19: r = 35'sd1833;
			5'd20: r = 35'sd917;
			5'd21: r = 35'sd458;
			5'd22: r = 35'sd229;
			5'd23: r = 35'sd115;
			5'd24: r = 35'sd57;
			5'd25: r = 35'sd29;
			5'd26: r = 35'sd14;
			5'd27: r = 35'sd7;
			5'd28: r = 35'sd4;
			5'd29: r = 35'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > 38'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -38'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic clips(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] e;
		e = SUM_W'(signed'(v[DATA_W-1:0]));
		return e != v;
	endfunction

endpackage

FILE: rtl/soc_trig.sv
// sine and cosine of an angle in degrees: modulo 360 reduction by a reciprocal
// multiply, then a shared rotation-mode cordic loop; depends on soc_pkg
module soc_trig #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 20
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [soc_pkg::DATA_W-1:0]      deg,
	output logic                                   done,
	output logic signed [soc_pkg::XY_W-1:0]        cos_o,
	output logic signed [soc_pkg::XY_W-1:0]        sin_o
);

	// 360 degrees is 45 << LB, so only the bits above LB need a modulo 45
	localparam int     LB     = FRAC_BITS + 3;
	localparam int     RW     = LB + 6;
	localparam int     UN_W   = 34 - LB;
	localparam int     QW     = UN_W - 5;
	localparam int     RCP_SH = 30;
	localparam longint OFS    = 45 * (((64'sd1 <<< (31 - LB)) + 44) / 45);
	localparam int     A_SH   = soc_pkg::ANG_FRAC - FRAC_BITS;
	localparam int     NSTEPS = (CORDIC_STEPS < soc_pkg::TABLE_LEN) ?
	                            CORDIC_STEPS : soc_pkg::TABLE_LEN;
	localparam logic [UN_W-1:0] OFS_V = UN_W'(OFS);
	localparam logic [UN_W-1:0] PER_V = UN_W'(45);
	localparam logic [24:0]     RCP_V = 25'd23860930;  // ceil(2^30 / 45)

	soc_pkg::trig_phase_t phase_q;
	logic [soc_pkg::STEP_W-1:0]          cnt_q;
	logic [UN_W-1:0]                     un_q;
	logic [LB-1:0]                       lo_q;
	logic [QW-1:0]                       quot_q;
	logic [RW-1:0]                       rem_q;
	logic signed [soc_pkg::ANG_W-1:0]    ang_q;
	logic signed [soc_pkg::XY_W-1:0]     x_q, y_q;
	logic                                neg_q;
	logic                                done_q;

	logic [UN_W+24:0]                    rcp_prod;
	logic [UN_W-1:0]                     rem_w;
	logic signed [soc_pkg::ANG_W-1:0]    ang_a, ang_b;
	logic                                neg_b;
	logic signed [soc_pkg::XY_W-1:0]     x_sh, y_sh;

	// high part offset to be non-negative, quotient by 45, then remainder
	always_comb begin
		rcp_prod = (UN_W+25)'(un_q) * (UN_W+25)'(RCP_V);
		rem_w    = un_q - UN_W'(quot_q) * PER_V;
	end

	// scale to 2^-24 degree, fold into [-90, 90]
	always_comb begin
		ang_a = soc_pkg::ANG_W'(rem_q) <<< A_SH;
		if (ang_a >= soc_pkg::ANG_180) begin
			ang_a = ang_a - soc_pkg::ANG_360;
		end
		neg_b = 1'b0;
		ang_b = ang_a;
		if (ang_a > soc_pkg::ANG_90) begin
			ang_b = ang_a - soc_pkg::ANG_180;
			neg_b = 1'b1;
		end else if (ang_a < -soc_pkg::ANG_90) begin
			ang_b = ang_a + soc_pkg::ANG_180;
			neg_b = 1'b1;
		end
	end

	assign x_sh = x_q >>> cnt_q;
	assign y_sh = y_q >>> cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= soc_pkg::T_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				soc_pkg::T_IDLE: begin
					if (start) begin
						phase_q <= soc_pkg::T_MOD;
						cnt_q   <= soc_pkg::STEP_W'(1);
					end
				end
				soc_pkg::T_MOD: begin
					if (cnt_q == '0) begin
						phase_q <= soc_pkg::T_PREP;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				soc_pkg::T_PREP: begin
					phase_q <= soc_pkg::T_ROT;
					cnt_q   <= '0;
				end
				soc_pkg::T_ROT: begin
					if (cnt_q == soc_pkg::STEP_W'(NSTEPS - 1)) begin
						phase_q <= soc_pkg::T_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: phase_q <= soc_pkg::T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			soc_pkg::T_IDLE: begin
				if (start) begin
					un_q <= UN_W'(deg >>> LB) + OFS_V;
					lo_q <= deg[LB-1:0];
				end
			end
			soc_pkg::T_MOD: begin
				if (cnt_q != '0) begin
					quot_q <= rcp_prod[UN_W+24:RCP_SH];
				end else begin
					rem_q <= {rem_w[5:0], lo_q};
				end
			end
			soc_pkg::T_PREP: begin
				ang_q <= ang_b;
				neg_q <= neg_b;
				x_q   <= soc_pkg::CORDIC_GAIN;
				y_q   <= '0;
			end
			soc_pkg::T_ROT: begin
				if (ang_q >= 0) begin
					x_q   <= x_q - y_sh;
					y_q   <= y_q + x_sh;
					ang_q <= ang_q - soc_pkg::atan_deg(cnt_q);
				end else begin
					x_q   <= x_q + y_sh;
					y_q   <= y_q - x_sh;
					ang_q <= ang_q + soc_pkg::atan_deg(cnt_q);
				end
			end
			default: ;
		endcase
	end

	assign done  = done_q;
	assign cos_o = neg_q ? -x_q : x_q;
	assign sin_o = neg_q ? -y_q : y_q;

endmodule

FILE: rtl/soc_dpath.sv
// datapath: start registers, camera state, trig unit, shared multiplier,
// saturating point update and the output register; depends on soc_pkg, soc_trig
module soc_dpath #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  soc_pkg::dp_cmd_t                     cmd,
	output soc_pkg::dp_status_t                  status,
	input  logic                                 cfg_we,
	input  logic [soc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [soc_pkg::DATA_W-1:0]           cfg_data,
	input  logic [soc_pkg::ACT_W-1:0]            in_action,
	input  logic [soc_pkg::DATA_W-1:0]           in_amount,
	output logic [soc_pkg::OUT_TDATA_W-1:0]      out_data
);

	localparam int W = soc_pkg::DATA_W;

	logic signed [W-1:0] cfg_q [soc_pkg::NUM_CFG];
	logic signed [W-1:0] radius_q, azim_q, polar_q;
	logic signed [W-1:0] tgt_q [3];
	logic signed [W-1:0] cam_q [3];
	soc_pkg::action_t    act_q;
	logic signed [W-1:0] amt_q;
	logic signed [W:0]   m_q;
	logic signed [soc_pkg::XY_W-1:0]  ca_q, sa_q, cp_q, sp_q;
	logic signed [soc_pkg::MUL_W-1:0] u0_q, u1_q;
	logic signed [soc_pkg::D_W-1:0]   d_q [3];
	logic                clip_q;
	logic [soc_pkg::OUT_TDATA_W-1:0] out_q;

	logic                                 trig_done;
	logic signed [soc_pkg::XY_W-1:0]      trig_cos, trig_sin;
	logic signed [soc_pkg::MUL_W-1:0]     op_a, op_b;
	logic signed [2*soc_pkg::MUL_W-1:0]   prod, prod_r;
	logic signed [soc_pkg::SUM_W-1:0]     sum_t [3];
	logic signed [soc_pkg::SUM_W-1:0]     sum_c [3];

	soc_trig #(
		.FRAC_BITS   (FRAC_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_trig (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.trig_start),
		.deg   (cmd.trig_sel ? polar_q : azim_q),
		.done  (trig_done),
		.cos_o (trig_cos),
		.sin_o (trig_sin)
	);

	assign status.trig_done = trig_done;

	always_comb begin
		unique case (cmd.mul_step)
			soc_pkg::MUL_U0: begin op_a = ca_q; op_b = sp_q; end
			soc_pkg::MUL_U1: begin op_a = sa_q; op_b = sp_q; end
			soc_pkg::MUL_D0: begin op_a = soc_pkg::MUL_W'(m_q); op_b = u0_q; end
			soc_pkg::MUL_D1: begin op_a = soc_pkg::MUL_W'(m_q); op_b = u1_q; end
			soc_pkg::MUL_D2: begin op_a = soc_pkg::MUL_W'(m_q); op_b = cp_q; end
			default: begin op_a = '0; op_b = '0; end
		endcase
		prod   = op_a * op_b;
		prod_r = (prod + (68'sd1 <<< 29)) >>> 30;
	end

	// new coordinates before saturation
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			unique case (act_q)
				soc_pkg::ACT_PIVOT_RAD, soc_pkg::ACT_PIVOT_AZ, soc_pkg::ACT_PIVOT_POL: begin
					sum_t[k] = soc_pkg::SUM_W'(cam_q[k]) - soc_pkg::SUM_W'(d_q[k]);
				end
				default: begin
					sum_t[k] = soc_pkg::SUM_W'(tgt_q[k]) + soc_pkg::SUM_W'(d_q[k]);
				end
			endcase
			sum_c[k] = soc_pkg::SUM_W'(cam_q[k]) + soc_pkg::SUM_W'(d_q[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < soc_pkg::NUM_CFG; k++) cfg_q[k] <= '0;
			radius_q <= '0;
			azim_q   <= '0;
			polar_q  <= '0;
			for (int k = 0; k < 3; k++) begin
				tgt_q[k] <= '0;
				cam_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (soc_pkg::cfg_reg_t'(cfg_index))
					soc_pkg::CFG_RADIUS:   cfg_q[0] <= cfg_data;
					soc_pkg::CFG_AZIMUTH:  cfg_q[1] <= cfg_data;
					soc_pkg::CFG_POLAR:    cfg_q[2] <= cfg_data;
					soc_pkg::CFG_TARGET_X: cfg_q[3] <= cfg_data;
					soc_pkg::CFG_TARGET_Y: cfg_q[4] <= cfg_data;
					soc_pkg::CFG_TARGET_Z: cfg_q[5] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.apply) begin
				unique case (act_q)
					soc_pkg::ACT_PLACE: begin
						radius_q <= cfg_q[0];
						azim_q   <= cfg_q[1];
						polar_q  <= cfg_q[2];
						for (int k = 0; k < 3; k++) tgt_q[k] <= cfg_q[3+k];
					end
					soc_pkg::ACT_ORBIT_AZ, soc_pkg::ACT_PIVOT_AZ:   azim_q   <= amt_q;
					soc_pkg::ACT_ORBIT_POL, soc_pkg::ACT_PIVOT_POL: polar_q  <= amt_q;
					soc_pkg::ACT_PIVOT_RAD:                         radius_q <= amt_q;
					default: ;
				endcase
			end
			if (cmd.update) begin
				for (int k = 0; k < 3; k++) begin
					unique case (act_q)
						soc_pkg::ACT_PLACE, soc_pkg::ACT_ORBIT_AZ, soc_pkg::ACT_ORBIT_POL:
							cam_q[k] <= soc_pkg::sat32(sum_t[k]);
						soc_pkg::ACT_PIVOT_RAD, soc_pkg::ACT_PIVOT_AZ, soc_pkg::ACT_PIVOT_POL:
							tgt_q[k] <= soc_pkg::sat32(sum_t[k]);
						default: begin
							tgt_q[k] <= soc_pkg::sat32(sum_t[k]);
							cam_q[k] <= soc_pkg::sat32(sum_c[k]);
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= soc_pkg::action_t'(in_action);
			amt_q <= in_amount;
		end
		if (cmd.apply) begin
			unique case (act_q)
				soc_pkg::ACT_PLACE:     m_q <= (W+1)'(cfg_q[0]);
				soc_pkg::ACT_DOLLY:     m_q <= (W+1)'(amt_q) - (W+1)'(radius_q);
				soc_pkg::ACT_PIVOT_RAD,
				soc_pkg::ACT_FORWARD:   m_q <= (W+1)'(amt_q);
				default:                m_q <= (W+1)'(radius_q);
			endcase
		end
		if (trig_done) begin
			if (cmd.trig_sel) begin
				cp_q <= trig_cos;
				sp_q <= trig_sin;
			end else begin
				ca_q <= trig_cos;
				sa_q <= trig_sin;
			end
		end
		if (cmd.mul_en) begin
			unique case (cmd.mul_step)
				soc_pkg::MUL_U0: u0_q   <= prod_r[soc_pkg::MUL_W-1:0];
				soc_pkg::MUL_U1: u1_q   <= prod_r[soc_pkg::MUL_W-1:0];
				soc_pkg::MUL_D0: d_q[0] <= prod_r[soc_pkg::D_W-1:0];
				soc_pkg::MUL_D1: d_q[1] <= prod_r[soc_pkg::D_W-1:0];
				soc_pkg::MUL_D2: d_q[2] <= prod_r[soc_pkg::D_W-1:0];
				default: ;
			endcase
		end
		if (cmd.update) begin
			unique case (act_q)
				soc_pkg::ACT_DOLLY, soc_pkg::ACT_FORWARD:
					clip_q <= soc_pkg::clips(sum_t[0]) | soc_pkg::clips(sum_t[1]) |
					          soc_pkg::clips(sum_t[2]) | soc_pkg::clips(sum_c[0]) |
					          soc_pkg::clips(sum_c[1]) | soc_pkg::clips(sum_c[2]);
				default:
					clip_q <= soc_pkg::clips(sum_t[0]) | soc_pkg::clips(sum_t[1]) |
					          soc_pkg::clips(sum_t[2]);
			endcase
		end
		if (cmd.out_load) begin
			out_q <= {7'd0, clip_q, polar_q, azim_q, radius_q,
			          tgt_q[2], tgt_q[1], tgt_q[0], cam_q[2], cam_q[1], cam_q[0]};
		end
	end

	assign out_data = out_q;

endmodule

FILE: rtl/soc_ctrl.sv
// controller state machine: sequences trig runs, multiplies and the update,
// owns the stream handshakes; depends on soc_pkg
module soc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  soc_pkg::dp_status_t status,
	output soc_pkg::dp_cmd_t    cmd
);

	soc_pkg::ctrl_state_t state_q, state_nx;
	logic                 out_valid_q;
	logic                 slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			soc_pkg::S_IDLE:     if (in_valid) state_nx = soc_pkg::S_APPLY;
			soc_pkg::S_APPLY:    state_nx = soc_pkg::S_TRIG_AZ;
			soc_pkg::S_TRIG_AZ:  state_nx = soc_pkg::S_WAIT_AZ;
			soc_pkg::S_WAIT_AZ:  if (status.trig_done) state_nx = soc_pkg::S_TRIG_POL;
			soc_pkg::S_TRIG_POL: state_nx = soc_pkg::S_WAIT_POL;
			soc_pkg::S_WAIT_POL: if (status.trig_done) state_nx = soc_pkg::S_MUL_U0;
			soc_pkg::S_MUL_U0:   state_nx = soc_pkg::S_MUL_U1;
			soc_pkg::S_MUL_U1:   state_nx = soc_pkg::S_MUL_D0;
			soc_pkg::S_MUL_D0:   state_nx = soc_pkg::S_MUL_D1;
			soc_pkg::S_MUL_D1:   state_nx = soc_pkg::S_MUL_D2;
			soc_pkg::S_MUL_D2:   state_nx = soc_pkg::S_UPDATE;
			soc_pkg::S_UPDATE:   state_nx = soc_pkg::S_OUT;
			soc_pkg::S_OUT:      if (slot_free) state_nx = soc_pkg::S_IDLE;
			default:             state_nx = soc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.mul_step = soc_pkg::MUL_U0;
		in_ready     = 1'b0;
		unique case (state_q)
			soc_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			soc_pkg::S_APPLY:    cmd.apply = 1'b1;
			soc_pkg::S_TRIG_AZ:  cmd.trig_start = 1'b1;
			soc_pkg::S_WAIT_AZ:  ;
			soc_pkg::S_TRIG_POL: begin
				cmd.trig_start = 1'b1;
				cmd.trig_sel   = 1'b1;
			end
			soc_pkg::S_WAIT_POL: cmd.trig_sel = 1'b1;
			soc_pkg::S_MUL_U0: begin cmd.mul_en = 1'b1; cmd.mul_step = soc_pkg::MUL_U0; end
			soc_pkg::S_MUL_U1: begin cmd.mul_en = 1'b1; cmd.mul_step = soc_pkg::MUL_U1; end
			soc_pkg::S_MUL_D0: begin cmd.mul_en = 1'b1; cmd.mul_step = soc_pkg::MUL_D0; end
			soc_pkg::S_MUL_D1: begin cmd.mul_en = 1'b1; cmd.mul_step = soc_pkg::MUL_D1; end
			soc_pkg::S_MUL_D2: begin cmd.mul_en = 1'b1; cmd.mul_step = soc_pkg::MUL_D2; end
			soc_pkg::S_UPDATE: cmd.update = 1'b1;
			soc_pkg::S_OUT:    cmd.out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= soc_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/spherical_orbit_camera.sv
// Orbit camera: each input transaction carries one action and an amount and
// produces one result with both points, the spherical values and a clip flag.
// Each event passes through the single shared trig unit, which runs a
// modulo-360 reduction and the cordic loop once for each angle.
// A new event is taken while the previous result still waits on the master side.
// depends on soc_pkg, soc_ctrl, soc_dpath
module spherical_orbit_camera #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [soc_pkg::DATA_W-1:0]          s_tdata,  // amount
	input  logic [soc_pkg::ACT_W-1:0]           s_tuser,  // action
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// camera_x, camera_y, camera_z, target_x, target_y, target_z,
	// radius_now, azimuth_now, polar_now, clipped, zero fill
	output logic [soc_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [soc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [soc_pkg::DATA_W-1:0]          cfg_data
);

	soc_pkg::dp_cmd_t    cmd;
	soc_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	soc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	soc_dpath #(
		.FRAC_BITS   (FRAC_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_action(s_tuser),
		.in_amount(s_tdata),
		.out_data (m_tdata)
	);

endmodule

FILE: rtl/soc_chk.sv
// port-level checks of the orbit camera, bound to the top level
// depends on soc_pkg and spherical_orbit_camera
module soc_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [soc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one event at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transaction taken while busy");

	// a result never shows in the cycle after acceptance
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

endmodule

bind spherical_orbit_camera soc_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.cfg_ready(cfg_ready)
);
